// ===== src/sre_pkg.sv =====
// Shared types and constants of the signed Rice encoder.
// Used by sre_seq, signed_rice_encoder_core and sre_checker; no dependencies.
`default_nettype none

package sre_pkg;

    // Widths of the data path and the configuration registers
    localparam int VALUE_BITS    = 32;
    localparam int KW            = 5;
    localparam int LIMIT_W       = 16;
    localparam int CFG_W         = 16;
    localparam int CFG_IDX_W     = 1;
    localparam int MAX_UNARY_DEF = 255;

    localparam logic [LIMIT_W-1:0] BYTE_COUNT_MAX = 16'hFFFF;
    localparam logic [KW-1:0]      RICE_K_RESET   = 5'd0;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET    = 16'hFFFF;

    // Item function codes
    localparam logic FUNC_ENCODE = 1'b0;
    localparam logic FUNC_FINISH = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RICE_K     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BYTE_LIMIT = 1'd1;

    // One result beat handed from the sequencer to the output stage
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       last;
        logic       too_long;
    } push_t;

endpackage

`default_nettype wire

// ===== src/sre_seq.sv =====
// Sequencer and shared bit packer of the signed Rice encoder: walks the
// sign, unary, terminator and low-bit segments, up to one byte a cycle while the output is free.
// Depends on sre_pkg.
`default_nettype none

module sre_seq #(
    parameter int MAX_UNARY = sre_pkg::MAX_UNARY_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 start,
    input  wire logic                                 func,
    input  wire logic signed [sre_pkg::VALUE_BITS-1:0] value,
    input  wire logic [sre_pkg::KW-1:0]               rice_k,
    input  wire logic                                 out_free,
    output logic                                      idle,
    output sre_pkg::push_t                            push
);

    localparam int VB      = sre_pkg::VALUE_BITS;
    localparam int UNARY_W = $clog2(MAX_UNARY + 1);
    localparam int BITS_W  = $clog2(MAX_UNARY + 34);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SIGN,
        ST_UNARY,
        ST_TERM,
        ST_LOWB,
        ST_FLUSH,
        ST_REJECT
    } state_t;

    state_t              state_reg, state_next;
    logic [6:0]          acc_reg, acc_next;
    logic [2:0]          cnt_reg, cnt_next;
    logic [VB-1:0]       mag_reg, mag_next;
    logic                neg_reg, neg_next;
    logic [UNARY_W-1:0]  hi_reg, hi_next;
    logic [BITS_W-1:0]   seg_left_reg, seg_left_next;
    logic [BITS_W-1:0]   bits_left_reg, bits_left_next;

    logic [VB-1:0]       value_u;
    logic [VB-1:0]       hi_full;
    logic [3:0]          space;
    logic [3:0]          take;
    logic [7:0]          take_mask;
    logic [7:0]          seg_data;
    logic [7:0]          merged;
    logic [3:0]          fill;
    logic                full;
    logic                step_ok;
    logic [BITS_W-1:0]   seg_rem;
    logic [BITS_W-1:0]   bits_rem;
    sre_pkg::push_t      push_c;

    assign value_u = value;
    assign hi_full = mag_reg >> rice_k;
    assign idle    = (state_reg == ST_IDLE);
    assign push    = push_c;

    // Packer: take as many bits of the current segment as fit the byte
    assign space     = 4'd8 - {1'b0, cnt_reg};
    assign take      = (seg_left_reg < BITS_W'(space)) ? seg_left_reg[3:0] : space;
    assign take_mask = 8'((9'h1 << take) - 9'h1);
    assign merged    = {1'b0, acc_reg} | ((seg_data & take_mask) << cnt_reg);
    assign fill      = {1'b0, cnt_reg} + take;
    assign full      = fill[3];
    assign step_ok   = !full || out_free;
    assign seg_rem   = seg_left_reg - BITS_W'(take);
    assign bits_rem  = bits_left_reg - BITS_W'(take);

    // Select the bits of the segment in progress
    always_comb
    begin
        case (state_reg)
            ST_SIGN:  seg_data = {7'd0, neg_reg};
            ST_UNARY: seg_data = 8'hFF;
            ST_LOWB:  seg_data = mag_reg[7:0];
            default:  seg_data = 8'd0;
        endcase
    end

    // Next state of the sequencer
    always_comb
    begin
        state_next     = state_reg;
        acc_next       = acc_reg;
        cnt_next       = cnt_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        hi_next        = hi_reg;
        seg_left_next  = seg_left_reg;
        bits_left_next = bits_left_reg;
        push_c         = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (func == sre_pkg::FUNC_FINISH)
                    begin
                        if (cnt_reg != 3'd0)
                            state_next = ST_FLUSH;
                    end
                    else
                    begin
                        // Magnitude by two's complement; the most negative
                        // value lands on its true magnitude unchanged
                        neg_next   = value_u[VB-1];
                        mag_next   = value_u[VB-1] ? (~value_u + 1'b1) : value_u;
                        state_next = ST_CHECK;
                    end
                end
            end

            ST_CHECK:
            begin
                if (hi_full > VB'(MAX_UNARY))
                    state_next = ST_REJECT;
                else
                begin
                    hi_next        = hi_full[UNARY_W-1:0];
                    seg_left_next  = BITS_W'(1);
                    bits_left_next = BITS_W'(hi_full[UNARY_W-1:0]) + BITS_W'(rice_k)
                                     + BITS_W'(2);
                    state_next     = ST_SIGN;
                end
            end

            ST_SIGN, ST_UNARY, ST_TERM, ST_LOWB:
            begin
                if (step_ok)
                begin
                    seg_left_next  = seg_rem;
                    bits_left_next = bits_rem;
                    if (full)
                    begin
                        push_c.valid = 1'b1;
                        push_c.data  = merged;
                        push_c.last  = (bits_rem < BITS_W'(8));
                        acc_next     = 7'd0;
                        cnt_next     = 3'd0;
                    end
                    else
                    begin
                        acc_next = merged[6:0];
                        cnt_next = fill[2:0];
                    end
                    if (state_reg == ST_LOWB)
                        mag_next = mag_reg >> take;

                    // Advance to the next segment once this one is spent
                    if (seg_rem == '0)
                    begin
                        case (state_reg)
                            ST_SIGN:
                            begin
                                if (hi_reg != '0)
                                begin
                                    seg_left_next = BITS_W'(hi_reg);
                                    state_next    = ST_UNARY;
                                end
                                else
                                begin
                                    seg_left_next = BITS_W'(1);
                                    state_next    = ST_TERM;
                                end
                            end
                            ST_UNARY:
                            begin
                                seg_left_next = BITS_W'(1);
                                state_next    = ST_TERM;
                            end
                            ST_TERM:
                            begin
                                if (rice_k != '0)
                                begin
                                    seg_left_next = BITS_W'(rice_k);
                                    state_next    = ST_LOWB;
                                end
                                else
                                    state_next = ST_IDLE;
                            end
                            default:
                                state_next = ST_IDLE;
                        endcase
                    end
                end
            end

            ST_FLUSH:
            begin
                if (out_free)
                begin
                    push_c.valid = 1'b1;
                    push_c.data  = {1'b0, acc_reg};
                    push_c.last  = 1'b1;
                    acc_next     = 7'd0;
                    cnt_next     = 3'd0;
                    state_next   = ST_IDLE;
                end
            end

            ST_REJECT:
            begin
                if (out_free)
                begin
                    push_c.valid    = 1'b1;
                    push_c.last     = 1'b1;
                    push_c.too_long = 1'b1;
                    state_next      = ST_IDLE;
                end
            end

            default:
                state_next = ST_IDLE;
        endcase
    end

    // Hold state, pending bits and segment counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            acc_reg       <= 7'd0;
            cnt_reg       <= 3'd0;
            seg_left_reg  <= '0;
            bits_left_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            cnt_reg       <= cnt_next;
            seg_left_reg  <= seg_left_next;
            bits_left_reg <= bits_left_next;
        end
    end

    // Item payload needs no reset
    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        neg_reg <= neg_next;
        hi_reg  <= hi_next;
    end

endmodule

`default_nettype wire

// ===== src/signed_rice_encoder_core.sv =====
// Top level of the signed Rice encoder: configuration registers, stream
// counters and the output register around the sre_seq sequencer.
// Depends on sre_pkg and sre_seq.
//
// Usage:
//   Input channel (in_valid/in_ready, func, value) takes one item at a time.
//   func encode turns value into a sign-magnitude Rice code; func finish pads
//   the pending bits with zeros and sends that byte. Output channel
//   (out_valid/out_ready) carries one byte per beat with last, overflow,
//   too_long and byte_index. Configuration is written through cfg_we,
//   cfg_index and cfg_data; the user must do so only while no item is in
//   flight, as the block itself does not enforce it.
// Packing:
//   The shared packer moves one segment piece of up to 8 bits a cycle
//   while the output register is free. A new item is accepted only once
//   the sequencer is idle again.
// Reset clears configuration to rice_k 0, byte_limit 65535, and empties the
// pending bits, byte count and overflow flag. When the receiver stalls, the
// byte waits in the output register and the packer stops at the next
// completed byte; in_ready returns once the item's bits are all packed.
`default_nettype none

module signed_rice_encoder_core #(
    parameter int MAX_UNARY = sre_pkg::MAX_UNARY_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic                                  func,
    input  wire logic signed [sre_pkg::VALUE_BITS-1:0] value,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic [7:0]                                 out_byte,
    output logic                                       last,
    output logic                                       overflow,
    output logic                                       too_long,
    output logic [sre_pkg::LIMIT_W-1:0]                byte_index,
    input  wire logic                                  cfg_we,
    input  wire logic [sre_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [sre_pkg::CFG_W-1:0]             cfg_data
);

    localparam int LW = sre_pkg::LIMIT_W;

    logic [sre_pkg::KW-1:0] rice_k_reg;
    logic [LW-1:0]          byte_limit_reg;
    logic [LW-1:0]          byte_count_reg, byte_count_next;
    logic                   overflow_flag_reg, overflow_flag_next;
    logic                   out_valid_reg, out_valid_next;
    logic [7:0]             out_byte_reg;
    logic                   last_reg;
    logic                   overflow_reg, overflow_next;
    logic                   too_long_reg;
    logic [LW-1:0]          byte_index_reg;

    logic                   seq_idle;
    logic                   out_free;
    logic                   ovf_now;
    sre_pkg::push_t         push;

    assign in_ready = seq_idle;
    assign out_free = !out_valid_reg || out_ready;

    sre_seq #(
        .MAX_UNARY (MAX_UNARY)
    ) u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (in_valid && seq_idle),
        .func     (func),
        .value    (value),
        .rice_k   (rice_k_reg),
        .out_free (out_free),
        .idle     (seq_idle),
        .push     (push)
    );

    // Update the stream counters on each data beat pushed by the sequencer; rejection beats leave them unchanged
    assign ovf_now = overflow_flag_reg || (byte_count_reg >= byte_limit_reg);

    always_comb
    begin
        byte_count_next    = byte_count_reg;
        overflow_flag_next = overflow_flag_reg;
        overflow_next      = overflow_flag_reg;
        if (push.valid && !push.too_long)
        begin
            overflow_next      = ovf_now;
            overflow_flag_next = ovf_now;
            if (byte_count_reg != sre_pkg::BYTE_COUNT_MAX)
                byte_count_next = byte_count_reg + 1'b1;
        end
    end

    // Drop the output beat when taken, load a new one when pushed
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (push.valid)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    // Hold configuration, counters and output control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rice_k_reg        <= sre_pkg::RICE_K_RESET;
            byte_limit_reg    <= sre_pkg::LIMIT_RESET;
            byte_count_reg    <= '0;
            overflow_flag_reg <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    sre_pkg::REG_RICE_K:     rice_k_reg     <= cfg_data[sre_pkg::KW-1:0];
                    sre_pkg::REG_BYTE_LIMIT: byte_limit_reg <= cfg_data[LW-1:0];
                    default:                 rice_k_reg     <= rice_k_reg;
                endcase
            end
            byte_count_reg    <= byte_count_next;
            overflow_flag_reg <= overflow_flag_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    // Load the output payload with each pushed beat
    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            out_byte_reg   <= push.data;
            last_reg       <= push.last;
            too_long_reg   <= push.too_long;
            overflow_reg   <= overflow_next;
            byte_index_reg <= byte_count_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign last       = last_reg;
    assign overflow   = overflow_reg;
    assign too_long   = too_long_reg;
    assign byte_index = byte_index_reg;

endmodule

`default_nettype wire

// ===== src/sre_checker.sv =====
// Port-level checks of the signed Rice encoder, bound to its top level.
// Depends on sre_pkg and signed_rice_encoder_core.
`default_nettype none

module sre_checker (
    input wire logic                                  clk,
    input wire logic                                  rst_n,
    input wire logic                                  in_valid,
    input wire logic                                  in_ready,
    input wire logic                                  func,
    input wire logic                                  out_valid,
    input wire logic                                  out_ready,
    input wire logic [7:0]                            out_byte,
    input wire logic                                  last,
    input wire logic                                  overflow,
    input wire logic                                  too_long,
    input wire logic [sre_pkg::LIMIT_W-1:0]           byte_index
);

    // A stalled output beat holds its byte
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_byte)))
        else $error("output beat changed while stalled");

    // A rejection is a lone, final, empty beat
    a_reject_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && too_long) |-> (last && out_byte == 8'd0))
        else $error("too_long beat not final or not empty");

    // Overflow stays set once a beat has shown it
    a_overflow_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && overflow) |=> (!out_valid || overflow))
        else $error("overflow flag dropped");

    // Byte index advances by one after each real byte until saturation
    a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !too_long && byte_index != sre_pkg::BYTE_COUNT_MAX)
        |=> (!out_valid || byte_index == $past(byte_index) + 16'd1))
        else $error("byte index did not advance by one");

    // An encode item keeps the input side busy in the next cycle
    a_encode_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && func == sre_pkg::FUNC_ENCODE) |=> !in_ready)
        else $error("input ready straight after an encode item");

endmodule

bind signed_rice_encoder_core sre_checker u_sre_checker (.*);

`default_nettype wire
